// ----- hw/rtl/decaying_random_jitter_defines.svh -----
// Assertion macros used by the jitter block's top-level RTL file
`ifndef DECAYING_RANDOM_JITTER_DEFINES_SVH
`define DECAYING_RANDOM_JITTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on aclk, off while aresetn is low
`define DRJ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("drj: implication check failed");
// next-cycle implication, clocked on aclk, off while aresetn is low
`define DRJ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("drj: next-cycle check failed");
`else
`define DRJ_ASSERT_IMP(lbl, ante, cons)
`define DRJ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/drj_pkg.sv -----
// Shared widths, constants and command codes of the jitter block
package drj_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int STR_W  = 16;
    localparam int TIME_W = 24;
    localparam int OFS_W  = 17;
    localparam int SEED_W = 64;
    localparam int DRAW_W = 24;
    localparam int PROD_W = STR_W + TIME_W;

    // stream payload layout
    localparam int S_TDATA_W = STR_W + 2 * TIME_W;
    localparam int M_INFO_W  = 2 * OFS_W + 1;
    localparam int M_TDATA_W = ((M_INFO_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_INFO_W;

    // generator constants
    localparam logic [SEED_W-1:0] SEED_RESET = 64'd1;
    localparam logic [SEED_W-1:0] XS_MUL     = 64'h2545_F491_4F6C_DD1D;
    localparam logic [DRAW_W-1:0] XS_MUL_LO  = XS_MUL[DRAW_W-1:0];
    localparam int XS_SH_A = 12;
    localparam int XS_SH_B = 25;
    localparam int XS_SH_C = 27;

    // command codes carried on s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_TRIGGER = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_SAMPLE  = 2'd2
    } cmd_t;

endpackage

// ----- hw/rtl/drj_rng.sv -----
// xorshift64* generator: one shift-xor per cycle, then a bit-serial low-24-bit multiply
module drj_rng (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        seed_we,
    input  logic [drj_pkg::SEED_W-1:0]  seed_data,
    input  logic                        start,
    output logic                        done,
    output logic [drj_pkg::DRAW_W-1:0]  draw
);

    localparam logic [1:0] MIX_LAST = 2'd2;
    localparam logic [4:0] MUL_LAST = 5'(drj_pkg::DRAW_W - 1);

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_MIX  = 3'b010,
        R_MUL  = 3'b100
    } rng_fsm_t;

    rng_fsm_t                    fsm_reg, fsm_next;
    logic [drj_pkg::SEED_W-1:0]  x_reg, x_next;
    logic [1:0]                  step_reg, step_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic [drj_pkg::DRAW_W-1:0]  mplier_reg, mplier_next;
    logic [drj_pkg::DRAW_W-1:0]  mcand_reg, mcand_next;
    logic [drj_pkg::DRAW_W-1:0]  acc_reg, acc_next;
    logic                        done_reg, done_next;
    logic [drj_pkg::SEED_W-1:0]  mix_val;

    // one of the three shift-xor steps, picked by the step counter
    always_comb begin
        case (step_reg)
            2'd0:    mix_val = x_reg ^ (x_reg >> drj_pkg::XS_SH_A);
            2'd1:    mix_val = x_reg ^ (x_reg << drj_pkg::XS_SH_B);
            default: mix_val = x_reg ^ (x_reg >> drj_pkg::XS_SH_C);
        endcase
    end

    // sequencer: mix, then multiply by the constant (only the low 24 bits matter)
    always_comb begin
        fsm_next    = fsm_reg;
        x_next      = x_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        case (fsm_reg)
            R_IDLE: begin
                if (start) begin
                    step_next = 2'd0;
                    fsm_next  = R_MIX;
                end
            end
            R_MIX: begin
                x_next    = mix_val;
                step_next = step_reg + 2'd1;
                if (step_reg == MIX_LAST) begin
                    mplier_next = mix_val[drj_pkg::DRAW_W-1:0];
                    mcand_next  = drj_pkg::XS_MUL_LO;
                    acc_next    = '0;
                    cnt_next    = '0;
                    fsm_next    = R_MUL;
                end
            end
            R_MUL: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[drj_pkg::DRAW_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[drj_pkg::DRAW_W-1:1]};
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST) begin
                    done_next = 1'b1;
                    fsm_next  = R_IDLE;
                end
            end
            default: begin
                fsm_next = R_IDLE;
            end
        endcase
        // a seed write reloads the state
        if (seed_we) begin
            x_next = seed_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg  <= R_IDLE;
            x_reg    <= drj_pkg::SEED_RESET;
            step_reg <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            fsm_reg  <= fsm_next;
            x_reg    <= x_next;
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign draw = acc_reg;

endmodule

// ----- hw/rtl/drj_amp.sv -----
// Decayed amplitude: bit-serial strength*left, then restoring divide by total
module drj_amp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [drj_pkg::STR_W-1:0]   strength,
    input  logic [drj_pkg::TIME_W-1:0]  left,
    input  logic [drj_pkg::TIME_W-1:0]  total,
    output logic                        done,
    output logic [drj_pkg::STR_W-1:0]   amp
);

    localparam int          PW      = drj_pkg::PROD_W;
    localparam int          SW      = drj_pkg::STR_W;
    localparam int          TW      = drj_pkg::TIME_W;
    localparam logic [3:0]  STEP_LAST = 4'(SW - 1);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MUL  = 3'b010,
        A_DIV  = 3'b100
    } amp_fsm_t;

    amp_fsm_t          fsm_reg, fsm_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [SW-1:0]     mplier_reg, mplier_next;
    logic [PW-1:0]     acc_reg, acc_next;
    logic              done_reg, done_next;
    logic [TW+1:0]     trial;

    // trial subtract of one divide step; top bit is the borrow
    assign trial = {1'b0, acc_reg[PW-1:SW], acc_reg[SW-1]} - {2'b00, total};

    // multiply MSB first, then divide; acc holds {remainder, dividend/quotient}
    // left never exceeds total, so the quotient fits in 16 bits
    always_comb begin
        fsm_next    = fsm_reg;
        cnt_next    = cnt_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        case (fsm_reg)
            A_IDLE: begin
                if (start) begin
                    acc_next    = '0;
                    mplier_next = strength;
                    cnt_next    = '0;
                    fsm_next    = A_MUL;
                end
            end
            A_MUL: begin
                acc_next = {acc_reg[PW-2:0], 1'b0}
                         + (mplier_reg[SW-1] ? {{SW{1'b0}}, left} : {PW{1'b0}});
                mplier_next = {mplier_reg[SW-2:0], 1'b0};
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg == STEP_LAST) begin
                    cnt_next = '0;
                    fsm_next = A_DIV;
                end
            end
            A_DIV: begin
                if (!trial[TW+1]) begin
                    acc_next = {trial[TW-1:0], acc_reg[SW-2:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == STEP_LAST) begin
                    done_next = 1'b1;
                    fsm_next  = A_IDLE;
                end
            end
            default: begin
                fsm_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg  <= A_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            fsm_reg  <= fsm_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign amp  = acc_reg[SW-1:0];

endmodule

// ----- hw/rtl/drj_scale.sv -----
// Offset scaling: bit-serial signed amp*n, floor by 2^23 via arithmetic shift
module drj_scale (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [drj_pkg::STR_W-1:0]          amp,
    input  logic [drj_pkg::DRAW_W-1:0]         draw,
    output logic                               done,
    output logic signed [drj_pkg::OFS_W-1:0]   offset
);

    localparam int          PW        = drj_pkg::PROD_W;
    localparam int          SW        = drj_pkg::STR_W;
    localparam int          DW        = drj_pkg::DRAW_W;
    localparam logic [3:0]  STEP_LAST = 4'(SW - 1);

    typedef enum logic [1:0] {
        C_IDLE = 2'b01,
        C_MUL  = 2'b10
    } scale_fsm_t;

    scale_fsm_t        fsm_reg, fsm_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [SW-1:0]     mplier_reg, mplier_next;
    logic [DW-1:0]     n_reg, n_next;
    logic [PW-1:0]     acc_reg, acc_next;
    logic              done_reg, done_next;

    // n = draw - 2^23 is the draw with its top bit flipped, read as signed
    always_comb begin
        fsm_next    = fsm_reg;
        cnt_next    = cnt_reg;
        mplier_next = mplier_reg;
        n_next      = n_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        case (fsm_reg)
            C_IDLE: begin
                if (start) begin
                    n_next      = {~draw[DW-1], draw[DW-2:0]};
                    mplier_next = amp;
                    acc_next    = '0;
                    cnt_next    = '0;
                    fsm_next    = C_MUL;
                end
            end
            C_MUL: begin
                acc_next = {acc_reg[PW-2:0], 1'b0}
                         + (mplier_reg[SW-1] ? {{(PW-DW){n_reg[DW-1]}}, n_reg} : {PW{1'b0}});
                mplier_next = {mplier_reg[SW-2:0], 1'b0};
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg == STEP_LAST) begin
                    done_next = 1'b1;
                    fsm_next  = C_IDLE;
                end
            end
            default: begin
                fsm_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg  <= C_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            fsm_reg  <= fsm_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mplier_reg <= mplier_next;
        n_reg      <= n_next;
        acc_reg    <= acc_next;
    end

    assign done   = done_reg;
    assign offset = signed'(acc_reg[PW-1:DW-1]);

endmodule

// ----- hw/rtl/decaying_random_jitter.sv -----
// Top level of the decaying random jitter block: command FSM, state and result register
//
//   channel   direction  contents
//   s_*       in         one command per transaction (trigger, tick, sample)
//   m_*       out        one result per command: offset_x, offset_y, active
//   cfg_*     in         generator seed write
//
// Trigger, tick, unknown commands and inactive samples go from acceptance through
// S_EXEC and S_WB to a registered m_tvalid. An active sample computes the amplitude
// (16-step multiply, 16-step divide), a second draw, a scale of the second axis,
// then a capture and write-back. One command is in work at a time. Reset (aresetn
// low, synchronous) clears the jitter state and loads seed 1. A result waiting on
// m_tready only holds the next write-back.
`include "decaying_random_jitter_defines.svh"

module decaying_random_jitter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // seed register
    input  logic                            cfg_we,
    input  logic [drj_pkg::SEED_W-1:0]      cfg_wdata,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [drj_pkg::S_TDATA_W-1:0]   s_tdata,   // strength, span_us, elapsed_us
    input  logic [drj_pkg::CMD_W-1:0]       s_tuser,   // cmd
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [drj_pkg::M_TDATA_W-1:0]   m_tdata    // offset_x, offset_y, active, zero pad
);

    localparam int SW  = drj_pkg::STR_W;
    localparam int TW  = drj_pkg::TIME_W;
    localparam int OW  = drj_pkg::OFS_W;
    localparam int ACT = 2 * OW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_AMP  = 6'b000100,
        S_DRY  = 6'b001000,
        S_SCY  = 6'b010000,
        S_WB   = 6'b100000
    } top_fsm_t;

    top_fsm_t                        fsm_reg, fsm_next;
    drj_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [SW-1:0]                   strength_reg, strength_next;
    logic [TW-1:0]                   span_reg, span_next;
    logic [TW-1:0]                   elapsed_reg, elapsed_next;
    logic [SW-1:0]                   cur_strength_reg, cur_strength_next;
    logic [TW-1:0]                   time_left_reg, time_left_next;
    logic [TW-1:0]                   time_total_reg, time_total_next;
    logic [OW-1:0]                   dx_reg, dx_next;
    logic [OW-1:0]                   dy_reg, dy_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [drj_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                            amp_start, amp_done;
    logic [SW-1:0]                   amp;
    logic                            rng_start, rng_done;
    logic [drj_pkg::DRAW_W-1:0]      draw;
    logic                            scale_start, scale_done;
    logic signed [OW-1:0]            offset;
    logic [SW-1:0]                   cur_active;
    logic                            s_accept;

    assign s_accept   = s_tvalid && s_tready;
    assign cur_active = (time_left_reg != '0) ? cur_strength_reg : '0;

    // amplitude, generator and scaling units
    drj_amp u_amp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (amp_start),
        .strength (cur_strength_reg),
        .left     (time_left_reg),
        .total    (time_total_reg),
        .done     (amp_done),
        .amp      (amp)
    );

    drj_rng u_rng (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_we   (cfg_we),
        .seed_data (cfg_wdata),
        .start     (rng_start),
        .done      (rng_done),
        .draw      (draw)
    );

    drj_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .amp     (amp),
        .draw    (draw),
        .done    (scale_done),
        .offset  (offset)
    );

    // command sequencer
    // the x draw ends before the amplitude, so it is ready when the amplitude is;
    // the x scale ends before the y draw
    always_comb begin
        fsm_next          = fsm_reg;
        cmd_next          = cmd_reg;
        strength_next     = strength_reg;
        span_next         = span_reg;
        elapsed_next      = elapsed_reg;
        cur_strength_next = cur_strength_reg;
        time_left_next    = time_left_reg;
        time_total_next   = time_total_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        amp_start         = 1'b0;
        rng_start         = 1'b0;
        scale_start       = 1'b0;
        case (fsm_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cmd_next      = drj_pkg::cmd_t'(s_tuser);
                    strength_next = s_tdata[SW-1:0];
                    span_next     = s_tdata[SW+TW-1:SW];
                    elapsed_next  = s_tdata[SW+2*TW-1:SW+TW];
                    fsm_next      = S_EXEC;
                end
            end
            S_EXEC: begin
                dx_next  = '0;
                dy_next  = '0;
                fsm_next = S_WB;
                case (cmd_reg)
                    drj_pkg::CMD_TRIGGER: begin
                        if (strength_reg != '0 && span_reg != '0 &&
                            strength_reg >= cur_active) begin
                            cur_strength_next = strength_reg;
                            time_left_next    = span_reg;
                            time_total_next   = span_reg;
                        end
                    end
                    drj_pkg::CMD_TICK: begin
                        if (time_left_reg != '0) begin
                            if (elapsed_reg >= time_left_reg) begin
                                time_left_next    = '0;
                                cur_strength_next = '0;
                            end else begin
                                time_left_next = time_left_reg - elapsed_reg;
                            end
                        end
                    end
                    drj_pkg::CMD_SAMPLE: begin
                        if (time_left_reg != '0 && cur_strength_reg != '0 &&
                            time_total_reg != '0) begin
                            amp_start = 1'b1;
                            rng_start = 1'b1;
                            fsm_next  = S_AMP;
                        end
                    end
                    default: begin
                        fsm_next = S_WB;
                    end
                endcase
            end
            S_AMP: begin
                if (amp_done) begin
                    scale_start = 1'b1;
                    rng_start   = 1'b1;
                    fsm_next    = S_DRY;
                end
            end
            S_DRY: begin
                if (rng_done) begin
                    dx_next     = offset;
                    scale_start = 1'b1;
                    fsm_next    = S_SCY;
                end
            end
            S_SCY: begin
                if (scale_done) begin
                    dy_next  = offset;
                    fsm_next = S_WB;
                end
            end
            S_WB: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{drj_pkg::M_PAD_W{1'b0}}, (time_left_reg != '0),
                                     dy_reg, dx_reg};
                    fsm_next      = S_IDLE;
                end
            end
            default: begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg          <= S_IDLE;
            cur_strength_reg <= '0;
            time_left_reg    <= '0;
            time_total_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            fsm_reg          <= fsm_next;
            cur_strength_reg <= cur_strength_next;
            time_left_reg    <= time_left_next;
            time_total_reg   <= time_total_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        strength_reg <= strength_next;
        span_reg     <= span_next;
        elapsed_reg  <= elapsed_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (fsm_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `DRJ_ASSERT_IMP(a_left_within_total, time_left_reg != '0, time_left_reg <= time_total_reg)
    `DRJ_ASSERT_IMP(a_left_has_strength, time_left_reg != '0, cur_strength_reg != '0)
    `DRJ_ASSERT_NXT(a_one_in_work, s_accept, !s_tready)
    `DRJ_ASSERT_IMP(a_inactive_zero_ofs, m_tvalid_reg && !m_tdata_reg[ACT], m_tdata_reg[ACT-1:0] == '0)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the decaying random jitter block
`timescale 1ns / 100ps

module tb;

    // local copies of the package widths
    localparam int CMD_W     = drj_pkg::CMD_W;
    localparam int STR_W     = drj_pkg::STR_W;
    localparam int TIME_W    = drj_pkg::TIME_W;
    localparam int OFS_W     = drj_pkg::OFS_W;
    localparam int SEED_W    = drj_pkg::SEED_W;
    localparam int DRAW_W    = drj_pkg::DRAW_W;
    localparam int S_TDATA_W = drj_pkg::S_TDATA_W;
    localparam int M_TDATA_W = drj_pkg::M_TDATA_W;

    // cmd code with no meaning in the block, still legal on the 2-bit field
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [STR_W-1:0] STR_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SEED_W-1:0] SEED_ONES = '1;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [OFS_W-1:0] off_x;
        logic signed [OFS_W-1:0] off_y;
        logic                    act;
    } shake_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [SEED_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // strength, span_us, elapsed_us
    logic [CMD_W-1:0]     s_tuser = '0;   // cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // offset_x, offset_y, active, zero pad

    // predictor state
    logic [STR_W-1:0]  str_q = '0;
    logic [TIME_W-1:0] left_q = '0;
    logic [TIME_W-1:0] total_q = '0;
    logic [SEED_W-1:0] rng_q = drj_pkg::SEED_RESET;

    shake_t      shake_due_q[$];
    int unsigned err_cnt = 0;
    int unsigned items_sent = 0;
    bit          no_idle = 1'b0;
    int unsigned rx_hold = 0;

    decaying_random_jitter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // xorshift64* step on the predicted generator state
    function automatic logic [SEED_W-1:0] next_draw();
        logic [SEED_W-1:0] x;
        x = rng_q;
        x = x ^ (x >> drj_pkg::XS_SH_A);
        x = x ^ (x << drj_pkg::XS_SH_B);
        x = x ^ (x >> drj_pkg::XS_SH_C);
        rng_q = x;
        return x * drj_pkg::XS_MUL;
    endfunction

    // floor(amp * n / 2^23), n = low 24 bits of the draw minus 2^23
    function automatic logic signed [OFS_W-1:0] scale_axis(logic [STR_W-1:0] amp,
                                                            logic [SEED_W-1:0] r);
        logic signed [63:0] n;
        logic signed [63:0] p;
        n = $signed({40'd0, r[DRAW_W-1:0]}) - 64'sd8388608;
        p = $signed({48'd0, amp}) * n;
        return OFS_W'(p >>> 23);
    endfunction

    // next result of the block for one command, updating the predicted state
    function automatic shake_t predict_shake(logic [CMD_W-1:0] cmd, logic [STR_W-1:0] str,
                                             logic [TIME_W-1:0] span, logic [TIME_W-1:0] el);
        shake_t           res;
        logic [STR_W-1:0] live;
        logic [39:0]      amp_full;
        logic [STR_W-1:0] amp;
        res.off_x = '0;
        res.off_y = '0;
        case (cmd)
            drj_pkg::CMD_TRIGGER: begin
                live = (left_q != 0) ? str_q : '0;
                if (str != 0 && span != 0 && str >= live) begin
                    str_q   = str;
                    left_q  = span;
                    total_q = span;
                end
            end
            drj_pkg::CMD_TICK: begin
                if (left_q != 0) begin
                    if (el >= left_q) begin
                        left_q = '0;
                        str_q  = '0;
                    end else begin
                        left_q = left_q - el;
                    end
                end
            end
            drj_pkg::CMD_SAMPLE: begin
                if (left_q != 0 && str_q != 0 && total_q != 0) begin
                    amp_full = ({24'd0, str_q} * {16'd0, left_q}) / {16'd0, total_q};
                    amp = (amp_full > 40'd65535) ? STR_MAX : amp_full[STR_W-1:0];
                    res.off_x = scale_axis(amp, next_draw());
                    res.off_y = scale_axis(amp, next_draw());
                end
            end
            default: ;
        endcase
        res.act = (left_q != 0);
        return res;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one command transaction; valid stays high when the next one follows at once
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [STR_W-1:0] str,
                            logic [TIME_W-1:0] span, logic [TIME_W-1:0] el);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {el, span, str};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        shake_due_q.push_back(predict_shake(cmd, str, span, el));
        items_sent++;
    endtask

    // let all results come out and the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (shake_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(logic [SEED_W-1:0] seed);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge aclk);
        cfg_we <= 1'b0;
        rng_q = seed;
    endtask

    // result side backpressure
    always @(posedge aclk) begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (no_idle || r < 65) begin
            m_tready <= 1'b1;
        end else if (r < 93) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(8, 40);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        shake_t exp_r;
        logic signed [OFS_W-1:0] got_x;
        logic signed [OFS_W-1:0] got_y;
        logic got_act;
        got_x   = m_tdata[OFS_W-1:0];
        got_y   = m_tdata[2*OFS_W-1:OFS_W];
        got_act = m_tdata[2*OFS_W];
        if (aresetn && m_tvalid && m_tready) begin
            if (shake_due_q.size() == 0) begin
                $error("unexpected result transaction: m_tdata=%h", m_tdata);
                err_cnt++;
            end else begin
                exp_r = shake_due_q.pop_front();
                if (got_x !== exp_r.off_x) begin
                    $error("offset_x: expected %0d, got %0d", exp_r.off_x, got_x);
                    err_cnt++;
                end
                if (got_y !== exp_r.off_y) begin
                    $error("offset_y: expected %0d, got %0d", exp_r.off_y, got_y);
                    err_cnt++;
                end
                if (got_act !== exp_r.act) begin
                    $error("active: expected %0b, got %0b", exp_r.act, got_act);
                    err_cnt++;
                end
            end
        end
    end

    // trigger rules, tick countdown, sampling edge cases on the reset seed
    task automatic test_directed();
        send_cmd(drj_pkg::CMD_SAMPLE, STR_MAX, TIME_MAX, TIME_MAX);   // inactive sample
        send_cmd(drj_pkg::CMD_TICK, STR_MAX, TIME_MAX, TIME_MAX);     // tick while idle
        send_cmd(CMD_UNUSED, STR_MAX, TIME_MAX, TIME_MAX);
        send_cmd(drj_pkg::CMD_TRIGGER, '0, TIME_MAX, '0);             // zero intensity
        send_cmd(drj_pkg::CMD_TRIGGER, STR_MAX, '0, '0);              // zero duration
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
        send_cmd(drj_pkg::CMD_TRIGGER, STR_MAX, TIME_MAX, '0);        // strongest, longest
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
        send_cmd(CMD_UNUSED, '0, '0, '0);                             // keeps active flag
        send_cmd(drj_pkg::CMD_TRIGGER, 16'h7FFF, 24'd100, TIME_MAX);  // weaker, ignored
        send_cmd(drj_pkg::CMD_TRIGGER, STR_MAX, 24'd1000, '0);        // equal, restarts
        send_cmd(drj_pkg::CMD_TICK, '0, '0, 24'd0);
        send_cmd(drj_pkg::CMD_TICK, '0, '0, 24'd999);
        send_cmd(drj_pkg::CMD_SAMPLE, STR_MAX, TIME_MAX, TIME_MAX);   // one unit left
        send_cmd(drj_pkg::CMD_TICK, '0, '0, 24'd1);                   // exact expiry
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
        send_cmd(drj_pkg::CMD_TRIGGER, 16'd1, 24'd1, '0);             // smallest jitter
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
        send_cmd(drj_pkg::CMD_TICK, '0, '0, TIME_MAX);                // overshoot
        send_cmd(drj_pkg::CMD_TRIGGER, 16'd1, 24'd5, '0);             // any level after expiry
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
    endtask

    // zero seed pins every draw to zero; all-ones seed is the other extreme
    task automatic test_seed_extremes();
        write_seed('0);
        send_cmd(drj_pkg::CMD_TRIGGER, STR_MAX, 24'd40, '0);
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
        send_cmd(drj_pkg::CMD_TICK, '0, '0, 24'd13);
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
        write_seed(SEED_ONES);
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
        send_cmd(drj_pkg::CMD_SAMPLE, '0, '0, '0);
        send_cmd(drj_pkg::CMD_TICK, '0, '0, TIME_MAX);
    endtask

    // jitter episodes with random content, plus raw noise commands
    task automatic run_random(int unsigned n_items);
        int unsigned stop_at;
        int unsigned len;
        int unsigned r;
        logic [STR_W-1:0]  str;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] el;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 99) < 85) begin
                r = $urandom_range(0, 9);
                str  = (r < 6) ? STR_W'($urandom) : STR_W'($urandom_range(1, 64));
                r = $urandom_range(0, 9);
                span = (r < 4) ? TIME_W'($urandom_range(1, 64)) :
                       (r < 8) ? TIME_W'($urandom_range(1, 5000)) : TIME_W'($urandom);
                send_cmd(drj_pkg::CMD_TRIGGER, str, span, TIME_W'($urandom));
                len = $urandom_range(2, 12);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 55) begin
                        send_cmd(drj_pkg::CMD_SAMPLE, STR_W'($urandom), TIME_W'($urandom),
                                 TIME_W'($urandom));
                    end else if (r < 88) begin
                        r = $urandom_range(0, 9);
                        el = (r < 7) ? TIME_W'($urandom_range(0, left_q / 3 + 1)) :
                             (r < 9) ? left_q : TIME_W'($urandom);
                        send_cmd(drj_pkg::CMD_TICK, STR_W'($urandom), TIME_W'($urandom), el);
                    end else begin
                        send_cmd(drj_pkg::CMD_TRIGGER, STR_W'($urandom_range(0, str_q + 16)),
                                 TIME_W'($urandom_range(0, 3000)), TIME_W'($urandom));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_cmd(CMD_W'($urandom_range(0, 3)), STR_W'($urandom),
                             TIME_W'($urandom), TIME_W'($urandom));
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // random episodes under several seeds
    task automatic test_random_phases();
        logic [SEED_W-1:0] seed;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: seed = drj_pkg::SEED_RESET;
                1: seed = SEED_ONES;
                default: seed = {$urandom, $urandom};
            endcase
            write_seed(seed);
            run_random(300);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_seed_extremes();
        test_random_phases();
        drain();
        if (err_cnt == 0) begin
            $display("decaying_random_jitter: match");
        end else begin
            $display("decaying_random_jitter: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("decaying_random_jitter: mismatch");
        $finish;
    end

endmodule
